// ----- hw/rtl/les_pkg.sv -----
// shared constants, widths and saturation helpers for the lorenz euler stepper
`timescale 1ns / 1ps
`default_nettype none

package les_pkg;

    localparam int Q_SHIFT   = 24;
    localparam int COORD_W   = 32;
    localparam int DT_W      = 25;
    localparam int D_W       = 40;
    localparam int D_HALF    = D_W / 2;
    localparam int DQ_W      = 46;
    localparam int ADV_W     = 43;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [DT_W-1:0] DT_MAX = 25'd16777216;

    localparam logic signed [COORD_W-1:0] SIGMA_RST = 32'sd134217728;
    localparam logic signed [COORD_W-1:0] BETA_RST  = 32'sd16777216;
    localparam logic signed [COORD_W-1:0] RHO_RST   = 32'sd251658240;
    localparam logic [DT_W-1:0]           DT_RST    = 25'd16777;
    localparam logic signed [COORD_W-1:0] SX_RST    = -32'sd8388608;
    localparam logic signed [COORD_W-1:0] SY_RST    = 32'sd1677722;
    localparam logic signed [COORD_W-1:0] SZ_RST    = 32'sd1677722;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RHO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd6;

    localparam logic signed [DQ_W-1:0] D_MAX_Q = 46'sd549755813887;
    localparam logic signed [DQ_W-1:0] D_MIN_Q = -46'sd549755813888;

    localparam logic signed [ADV_W-1:0] C_MAX_Q = 43'sd2147483647;
    localparam logic signed [ADV_W-1:0] C_MIN_Q = -43'sd2147483648;

    typedef struct packed {
        logic                    ovf;
        logic signed [D_W-1:0]   val;
    } d_sat_t;

    typedef struct packed {
        logic                      ovf;
        logic signed [COORD_W-1:0] val;
    } c_sat_t;

    // clamp a derivative to signed q16.24
    function automatic d_sat_t sat_d(input logic signed [DQ_W-1:0] v);
        d_sat_t r;
        if (v > D_MAX_Q) begin
            r.ovf = 1'b1;
            r.val = D_MAX_Q[D_W-1:0];
        end else if (v < D_MIN_Q) begin
            r.ovf = 1'b1;
            r.val = D_MIN_Q[D_W-1:0];
        end else begin
            r.ovf = 1'b0;
            r.val = v[D_W-1:0];
        end
        return r;
    endfunction

    // clamp an advanced coordinate to signed 32 bits
    function automatic c_sat_t sat_c(input logic signed [ADV_W-1:0] v);
        c_sat_t r;
        if (v > C_MAX_Q) begin
            r.ovf = 1'b1;
            r.val = C_MAX_Q[COORD_W-1:0];
        end else if (v < C_MIN_Q) begin
            r.ovf = 1'b1;
            r.val = C_MIN_Q[COORD_W-1:0];
        end else begin
            r.ovf = 1'b0;
            r.val = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lorenz_euler_stepper.sv -----
// lorenz attractor explicit euler stepper, signed q8.24, one shared multiplier
// restart tick: loads the start point and goes straight to the output hand-off
// step tick: ten products through the registered multiplier, then the hand-off;
// a new transfer is taken only back in idle; a held output register adds its wait
// synchronous active-low reset loads the default coefficients, dt and start point,
// and puts the position at the start point
`timescale 1ns / 1ps
`default_nettype none

module lorenz_euler_stepper (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [les_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [les_pkg::COORD_W-1:0]            cfg_data,
    // tick input
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_restart,
    // point output
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [les_pkg::COORD_W-1:0]          m_x_out,
    output logic signed [les_pkg::COORD_W-1:0]          m_y_out,
    output logic signed [les_pkg::COORD_W-1:0]          m_z_out,
    output logic                                        m_saturated
);

    localparam int CW = les_pkg::COORD_W;
    localparam int MW = les_pkg::MUL_W;
    localparam int DW = les_pkg::D_W;
    localparam int DH = les_pkg::D_HALF;
    localparam int QW = les_pkg::DQ_W;
    localparam int AW = les_pkg::ADV_W;
    localparam int SUM_W = QW + DH;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CALC  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    // multiplier schedule, product of one op is consumed at the next
    localparam logic [3:0] OP_SIG   = 4'd0;
    localparam logic [3:0] OP_RHO   = 4'd1;
    localparam logic [3:0] OP_XY    = 4'd2;
    localparam logic [3:0] OP_BETA  = 4'd3;
    localparam logic [3:0] OP_DX_HI = 4'd4;
    localparam logic [3:0] OP_DX_LO = 4'd5;
    localparam logic [3:0] OP_DY_HI = 4'd6;
    localparam logic [3:0] OP_DY_LO = 4'd7;
    localparam logic [3:0] OP_DZ_HI = 4'd8;
    localparam logic [3:0] OP_DZ_LO = 4'd9;
    localparam logic [3:0] OP_LAST  = 4'd10;

    state_t state_reg, state_next;
    logic [3:0] op_reg, op_next;

    logic signed [CW-1:0] sigma_reg, sigma_next;
    logic signed [CW-1:0] beta_reg, beta_next;
    logic signed [CW-1:0] rho_reg, rho_next;
    logic [les_pkg::DT_W-1:0] step_size_reg, step_size_next;
    logic signed [CW-1:0] start_x_reg, start_x_next;
    logic signed [CW-1:0] start_y_reg, start_y_next;
    logic signed [CW-1:0] start_z_reg, start_z_next;

    logic signed [CW-1:0] pos_x_reg, pos_x_next;
    logic signed [CW-1:0] pos_y_reg, pos_y_next;
    logic signed [CW-1:0] pos_z_reg, pos_z_next;
    logic sat_reg, sat_next;
    logic m_valid_reg, m_valid_next;

    logic signed [DW-1:0] dx_reg, dx_next;
    logic signed [DW-1:0] dy_reg, dy_next;
    logic signed [DW-1:0] dz_reg, dz_next;
    logic signed [QW-1:0] t_reg, t_next;
    logic signed [QW-1:0] hi_reg, hi_next;
    logic signed [CW-1:0] m_x_reg, m_x_next;
    logic signed [CW-1:0] m_y_reg, m_y_next;
    logic signed [CW-1:0] m_z_reg, m_z_next;
    logic m_sat_reg, m_sat_next;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [les_pkg::PROD_W-1:0] mul_p;

    logic [les_pkg::DT_W-1:0] dt_eff;
    logic signed [CW:0] diff_yx, diff_rz;
    logic signed [QW-1:0] prod_q;
    logic signed [SUM_W-1:0] inc_sum;
    logic signed [CW-1:0] adv_coord;
    logic signed [AW-1:0] adv_val;
    les_pkg::d_sat_t d_res;
    les_pkg::c_sat_t c_res;
    logic s_xfer, m_xfer;

    les_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = m_valid_reg && m_ready;

    assign dt_eff  = (step_size_reg > les_pkg::DT_MAX) ? les_pkg::DT_MAX : step_size_reg;
    assign diff_yx = (CW+1)'(pos_y_reg) - (CW+1)'(pos_x_reg);
    assign diff_rz = (CW+1)'(rho_reg) - (CW+1)'(pos_z_reg);

    // floor shift of the product back to q.24
    assign prod_q  = QW'(mul_p >>> les_pkg::Q_SHIFT);
    assign inc_sum = $signed({hi_reg, {DH{1'b0}}}) + SUM_W'(mul_p);

    always_comb begin
        case (op_reg)
            OP_DZ_HI: adv_coord = pos_y_reg;
            OP_LAST:  adv_coord = pos_z_reg;
            default:  adv_coord = pos_x_reg;
        endcase
    end

    assign adv_val = AW'(inc_sum >>> les_pkg::Q_SHIFT) + AW'(adv_coord);
    assign c_res   = les_pkg::sat_c(adv_val);

    always_comb begin
        case (op_reg)
            OP_RHO:   d_res = les_pkg::sat_d(prod_q);
            OP_XY:    d_res = les_pkg::sat_d(prod_q - QW'(pos_y_reg));
            default:  d_res = les_pkg::sat_d(t_reg - prod_q);
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_SIG: begin
                mul_a = MW'(sigma_reg);
                mul_b = MW'(diff_yx);
            end
            OP_RHO: begin
                mul_a = MW'(pos_x_reg);
                mul_b = MW'(diff_rz);
            end
            OP_XY: begin
                mul_a = MW'(pos_x_reg);
                mul_b = MW'(pos_y_reg);
            end
            OP_BETA: begin
                mul_a = MW'(beta_reg);
                mul_b = MW'(pos_z_reg);
            end
            OP_DX_HI: begin
                mul_a = $signed(MW'(dt_eff));
                mul_b = MW'($signed(dx_reg[DW-1:DH]));
            end
            OP_DX_LO: begin
                mul_a = $signed(MW'(dt_eff));
                mul_b = $signed(MW'(dx_reg[DH-1:0]));
            end
            OP_DY_HI: begin
                mul_a = $signed(MW'(dt_eff));
                mul_b = MW'($signed(dy_reg[DW-1:DH]));
            end
            OP_DY_LO: begin
                mul_a = $signed(MW'(dt_eff));
                mul_b = $signed(MW'(dy_reg[DH-1:0]));
            end
            OP_DZ_HI: begin
                mul_a = $signed(MW'(dt_eff));
                mul_b = MW'($signed(dz_reg[DW-1:DH]));
            end
            OP_DZ_LO: begin
                mul_a = $signed(MW'(dt_eff));
                mul_b = $signed(MW'(dz_reg[DH-1:0]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        sigma_next     = sigma_reg;
        beta_next      = beta_reg;
        rho_next       = rho_reg;
        step_size_next = step_size_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        start_z_next   = start_z_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        sat_next       = sat_reg;
        m_valid_next   = m_valid_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        t_next         = t_reg;
        hi_next        = hi_reg;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_z_next       = m_z_reg;
        m_sat_next     = m_sat_reg;

        if (cfg_valid) begin
            case (cfg_index)
                les_pkg::CFG_SIGMA:   sigma_next     = $signed(cfg_data);
                les_pkg::CFG_BETA:    beta_next      = $signed(cfg_data);
                les_pkg::CFG_RHO:     rho_next       = $signed(cfg_data);
                les_pkg::CFG_STEP:    step_size_next = cfg_data[les_pkg::DT_W-1:0];
                les_pkg::CFG_START_X: start_x_next   = $signed(cfg_data);
                les_pkg::CFG_START_Y: start_y_next   = $signed(cfg_data);
                les_pkg::CFG_START_Z: start_z_next   = $signed(cfg_data);
                default: ;
            endcase
        end

        if (m_xfer) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    sat_next = 1'b0;
                    op_next  = OP_SIG;
                    if (s_restart) begin
                        pos_x_next = start_x_reg;
                        pos_y_next = start_y_reg;
                        pos_z_next = start_z_reg;
                        state_next = ST_WRITE;
                    end else begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                op_next = op_reg + 4'd1;
                case (op_reg)
                    OP_RHO: begin
                        dx_next  = d_res.val;
                        sat_next = sat_reg | d_res.ovf;
                    end
                    OP_XY: begin
                        dy_next  = d_res.val;
                        sat_next = sat_reg | d_res.ovf;
                    end
                    OP_BETA: begin
                        t_next = prod_q;
                    end
                    OP_DX_HI: begin
                        dz_next  = d_res.val;
                        sat_next = sat_reg | d_res.ovf;
                    end
                    OP_DX_LO, OP_DY_LO, OP_DZ_LO: begin
                        hi_next = mul_p[QW-1:0];
                    end
                    OP_DY_HI: begin
                        pos_x_next = c_res.val;
                        sat_next   = sat_reg | c_res.ovf;
                    end
                    OP_DZ_HI: begin
                        pos_y_next = c_res.val;
                        sat_next   = sat_reg | c_res.ovf;
                    end
                    OP_LAST: begin
                        pos_z_next = c_res.val;
                        sat_next   = sat_reg | c_res.ovf;
                        state_next = ST_WRITE;
                    end
                    default: ;
                endcase
            end
            ST_WRITE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_x_next     = pos_x_reg;
                    m_y_next     = pos_y_reg;
                    m_z_next     = pos_z_reg;
                    m_sat_next   = sat_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SIG;
            sigma_reg     <= les_pkg::SIGMA_RST;
            beta_reg      <= les_pkg::BETA_RST;
            rho_reg       <= les_pkg::RHO_RST;
            step_size_reg <= les_pkg::DT_RST;
            start_x_reg   <= les_pkg::SX_RST;
            start_y_reg   <= les_pkg::SY_RST;
            start_z_reg   <= les_pkg::SZ_RST;
            pos_x_reg     <= les_pkg::SX_RST;
            pos_y_reg     <= les_pkg::SY_RST;
            pos_z_reg     <= les_pkg::SZ_RST;
            sat_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            sigma_reg     <= sigma_next;
            beta_reg      <= beta_next;
            rho_reg       <= rho_next;
            step_size_reg <= step_size_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            start_z_reg   <= start_z_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            pos_z_reg     <= pos_z_next;
            sat_reg       <= sat_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        dz_reg    <= dz_next;
        t_reg     <= t_next;
        hi_reg    <= hi_next;
        m_x_reg   <= m_x_next;
        m_y_reg   <= m_y_next;
        m_z_reg   <= m_z_next;
        m_sat_reg <= m_sat_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_x_out     = m_x_reg;
    assign m_y_out     = m_y_reg;
    assign m_z_out     = m_z_reg;
    assign m_saturated = m_sat_reg;

    // a transfer in always leaves the block busy on the next cycle
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_ready)
        else $error("input taken while a tick is in work");

    // a restart goes straight to the output hand-off with a clear flag
    a_restart_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_restart) |=> (state_reg == ST_WRITE) && !sat_reg)
        else $error("restart tick did not go to hand-off");

    // a new result appears only out of the hand-off state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == ST_WRITE))
        else $error("result raised outside hand-off");

    // the multiplier schedule never runs past its last op
    a_op_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |-> (op_reg <= OP_LAST))
        else $error("op counter out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/les_mul.sv -----
// shared signed multiplier with a registered product
`timescale 1ns / 1ps
`default_nettype none

module les_mul (
    input  wire logic                                  aclk,
    input  wire logic signed [les_pkg::MUL_W-1:0]      mul_a,
    input  wire logic signed [les_pkg::MUL_W-1:0]      mul_b,
    output logic signed [les_pkg::PROD_W-1:0]          mul_p
);

    logic signed [les_pkg::PROD_W-1:0] prod_reg;
    logic signed [les_pkg::PROD_W-1:0] prod_next;

    assign prod_next = les_pkg::PROD_W'(mul_a) * les_pkg::PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign mul_p = prod_reg;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the lorenz euler stepper with a fixed point trajectory predictor
`timescale 1ns / 1ps

module tb;

    localparam int TOTAL_ITEMS = 1320;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 30;
    localparam int CW = les_pkg::COORD_W;
    localparam int IW = les_pkg::CFG_IDX_W;

    localparam logic signed [CW-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CW-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic [IW-1:0] CFG_UNUSED = 3'd7;
    localparam longint DERIV_HI = (longint'(1) <<< 39) - 1;
    localparam longint DERIV_LO = -(longint'(1) <<< 39);

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 sat;
    } point_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IW-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_restart = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [CW-1:0] m_x_out;
    logic signed [CW-1:0] m_y_out;
    logic signed [CW-1:0] m_z_out;
    logic m_saturated;

    // register mirror and current point
    logic signed [CW-1:0] sigma_r = les_pkg::SIGMA_RST;
    logic signed [CW-1:0] beta_r = les_pkg::BETA_RST;
    logic signed [CW-1:0] rho_r = les_pkg::RHO_RST;
    logic [les_pkg::DT_W-1:0] dt_r = les_pkg::DT_RST;
    logic signed [CW-1:0] start_x_r = les_pkg::SX_RST;
    logic signed [CW-1:0] start_y_r = les_pkg::SY_RST;
    logic signed [CW-1:0] start_z_r = les_pkg::SZ_RST;
    logic signed [CW-1:0] pos_x = les_pkg::SX_RST;
    logic signed [CW-1:0] pos_y = les_pkg::SY_RST;
    logic signed [CW-1:0] pos_z = les_pkg::SZ_RST;

    point_t point_q[$];
    int items_sent = 0;
    int errors = 0;
    bit src_idle = 1'b1;
    bit rcv_stall = 1'b1;
    int hold_asks = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    lorenz_euler_stepper u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_x_out     (m_x_out),
        .m_y_out     (m_y_out),
        .m_z_out     (m_z_out),
        .m_saturated (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint clamp_deriv(input longint v, inout bit sat);
        if (v > DERIV_HI) begin
            sat = 1'b1;
            return DERIV_HI;
        end
        if (v < DERIV_LO) begin
            sat = 1'b1;
            return DERIV_LO;
        end
        return v;
    endfunction

    function automatic logic signed [CW-1:0] move_coord(input longint c, input longint d,
                                                         input longint dt, inout bit sat);
        longint n;
        n = c + ((dt * d) >>> les_pkg::Q_SHIFT);
        if (n > longint'(COORD_MAX)) begin
            sat = 1'b1;
            return COORD_MAX;
        end
        if (n < longint'(COORD_MIN)) begin
            sat = 1'b1;
            return COORD_MIN;
        end
        return n[CW-1:0];
    endfunction

    // advance the mirrored point by one tick, or reset it to the start on a restart, and queue the point it gives
    task automatic euler_tick(input bit restart);
        point_t p;
        longint x, y, z, dt, dx, dy, dz;
        bit sat;
        sat = 1'b0;
        if (restart) begin
            pos_x = start_x_r;
            pos_y = start_y_r;
            pos_z = start_z_r;
        end else begin
            x = pos_x;
            y = pos_y;
            z = pos_z;
            dt = (dt_r > les_pkg::DT_MAX) ? longint'(les_pkg::DT_MAX) : longint'(dt_r);
            dx = clamp_deriv((longint'(sigma_r) * (y - x)) >>> les_pkg::Q_SHIFT, sat);
            dy = clamp_deriv(((x * (longint'(rho_r) - z)) >>> les_pkg::Q_SHIFT) - y, sat);
            dz = clamp_deriv(((x * y) >>> les_pkg::Q_SHIFT)
                             - ((longint'(beta_r) * z) >>> les_pkg::Q_SHIFT), sat);
            pos_x = move_coord(x, dx, dt, sat);
            pos_y = move_coord(y, dy, dt, sat);
            pos_z = move_coord(z, dz, dt, sat);
        end
        p.x = pos_x;
        p.y = pos_y;
        p.z = pos_z;
        p.sat = sat;
        point_q.push_back(p);
    endtask

    // one tick transfer; valid stays high on return so back-to-back ticks keep it up
    task automatic send_tick(input bit restart);
        int gap;
        gap = 0;
        if (src_idle && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        euler_tick(restart);
        items_sent++;
    endtask

    task automatic drain_points();
        s_valid <= 1'b0;
        while (point_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            les_pkg::CFG_SIGMA: sigma_r = val;
            les_pkg::CFG_BETA: beta_r = val;
            les_pkg::CFG_RHO: rho_r = val;
            les_pkg::CFG_STEP: dt_r = val[les_pkg::DT_W-1:0];
            les_pkg::CFG_START_X: start_x_r = val;
            les_pkg::CFG_START_Y: start_y_r = val;
            les_pkg::CFG_START_Z: start_z_r = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_coefs(input logic [CW-1:0] sg, input logic [CW-1:0] bt,
                               input logic [CW-1:0] rh, input logic [CW-1:0] dt);
        write_reg(les_pkg::CFG_SIGMA, sg);
        write_reg(les_pkg::CFG_BETA, bt);
        write_reg(les_pkg::CFG_RHO, rh);
        write_reg(les_pkg::CFG_STEP, dt);
    endtask

    task automatic write_start(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                               input logic [CW-1:0] sz);
        write_reg(les_pkg::CFG_START_X, sx);
        write_reg(les_pkg::CFG_START_Y, sy);
        write_reg(les_pkg::CFG_START_Z, sz);
    endtask

    // q8.24 value mostly in [lo, hi], now and then an extreme or any 32-bit pattern
    function automatic logic [CW-1:0] rand_q(input int lo, input int hi);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 3))
                0: return COORD_MIN;
                1: return COORD_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        if (pick == 1) return $urandom;
        return $urandom_range(0, (hi - lo) << les_pkg::Q_SHIFT) + (lo <<< les_pkg::Q_SHIFT);
    endfunction

    function automatic logic [CW-1:0] rand_dt();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return $urandom_range(0, 1 << 20);
        if (pick == 7) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return les_pkg::DT_MAX;
                2: return 32'h01FF_FFFF;
                default: return $urandom_range(les_pkg::DT_MAX + 1, 32'h01FF_FFFF);
            endcase
        end
        return $urandom;
    endfunction

    task automatic randomize_config();
        if ($urandom_range(0, 3) != 0) write_reg(les_pkg::CFG_SIGMA, rand_q(0, 20));
        if ($urandom_range(0, 3) != 0) write_reg(les_pkg::CFG_BETA, rand_q(0, 6));
        if ($urandom_range(0, 3) != 0) write_reg(les_pkg::CFG_RHO, rand_q(0, 60));
        if ($urandom_range(0, 3) != 0) write_reg(les_pkg::CFG_STEP, rand_dt());
        if ($urandom_range(0, 3) != 0) write_reg(les_pkg::CFG_START_X, rand_q(-30, 30));
        if ($urandom_range(0, 3) != 0) write_reg(les_pkg::CFG_START_Y, rand_q(-30, 30));
        if ($urandom_range(0, 3) != 0) write_reg(les_pkg::CFG_START_Z, rand_q(-30, 30));
        if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, $urandom);
    endtask

    // point held since reset, then a restart from the default start
    task automatic test_reset_state();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_register_extremes();
        drain_points();
        write_coefs(COORD_MAX, COORD_MIN, COORD_MAX, les_pkg::DT_MAX);
        write_start(COORD_MIN, COORD_MAX, '0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_points();
        // dt field above one, upper data bits set as well
        write_coefs(COORD_MIN, COORD_MAX, COORD_MIN, 32'hFFFF_FFFF);
        write_start(COORD_MAX, COORD_MIN, COORD_MIN);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_points();
        // zero step leaves the point where it is
        write_coefs(les_pkg::SIGMA_RST, les_pkg::BETA_RST, les_pkg::RHO_RST, '0);
        write_start(32'sh0A00_0000, -32'sh0500_0000, 32'sh1400_0000);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_points();
        // unused index changes nothing
        write_reg(CFG_UNUSED, $urandom);
        write_reg(les_pkg::CFG_STEP, les_pkg::DT_RST);
        send_tick(1'b0);
    endtask

    // new start values only show up at the next restart
    task automatic test_deferred_start();
        drain_points();
        write_start(les_pkg::SX_RST, les_pkg::SY_RST, les_pkg::SZ_RST);
        write_coefs(les_pkg::SIGMA_RST, les_pkg::BETA_RST, les_pkg::RHO_RST, 32'd1 << 20);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // receiver holds off while ticks keep coming, so the input side backs up
    task automatic test_backpressure();
        drain_points();
        src_idle = 1'b0;
        hold_asks++;
        repeat (12) send_tick($urandom_range(0, 3) == 0);
        drain_points();
        src_idle = 1'b1;
    endtask

    task automatic test_random_phases();
        int phase;
        int n;
        bit quiet;
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            drain_points();
            randomize_config();
            quiet = (phase == 2);
            src_idle = !quiet;
            rcv_stall = !quiet;
            n = quiet ? 200 : $urandom_range(40, 120);
            if ($urandom_range(0, 1)) send_tick(1'b1);
            repeat (n) send_tick($urandom_range(0, 15) == 0);
            phase++;
        end
        src_idle = 1'b1;
        rcv_stall = 1'b1;
    endtask

    task automatic check_point();
        point_t p;
        if (point_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time, m_x_out, m_y_out, m_z_out);
            return;
        end
        p = point_q.pop_front();
        if (m_x_out !== p.x || m_y_out !== p.y || m_z_out !== p.z || m_saturated !== p.sat) begin
            errors++;
            if (m_x_out !== p.x) $display("%0t: x expected %0d actual %0d", $time, p.x, m_x_out);
            if (m_y_out !== p.y) $display("%0t: y expected %0d actual %0d", $time, p.y, m_y_out);
            if (m_z_out !== p.z) $display("%0t: z expected %0d actual %0d", $time, p.z, m_z_out);
            if (m_saturated !== p.sat)
                $display("%0t: saturated expected %0b actual %0b", $time, p.sat, m_saturated);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_point();
        if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (rcv_stall) begin
            m_ready <= ($urandom_range(0, 99) >= 20);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("lorenz_euler_stepper regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_register_extremes();
        test_deferred_start();
        test_backpressure();
        test_random_phases();
        drain_points();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && point_q.size() == 0) begin
            $display("lorenz_euler_stepper regression: pass");
        end else begin
            $display("lorenz_euler_stepper regression: fail");
        end
        $finish;
    end

endmodule
